// ----- rtl/kpb_pkg.sv -----
`default_nettype none

package kpb_pkg;

   localparam int KMER_LEN  = 8;
   localparam int KEY_W     = 2 * KMER_LEN;
   localparam int TBL_DEPTH = 1 << KEY_W;
   localparam int RUN_W     = $clog2(KMER_LEN + 1);

   localparam int ACT_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int POS_W     = 8;
   localparam int RLEN_W    = 8;
   localparam int NUM_W     = 16;
   localparam int COUNT_W   = 17;
   localparam int WORD_W    = 64;
   localparam int BIT_W     = 6;
   localparam int PW_ADDR_W = 10;
   localparam int PW_DEPTH  = 1 << PW_ADDR_W;
   localparam int CSR_W     = 32;
   localparam int PADDR_W   = 3;

   // clear sweep covers both the k-mer table and the presence words
   localparam int CLR_W = (KEY_W > PW_ADDR_W) ? KEY_W : PW_ADDR_W;

   localparam logic [ACT_W-1:0] ACT_INDEX = 2'd0;
   localparam logic [ACT_W-1:0] ACT_MARK  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   localparam logic [POS_W-1:0]  POS_MAX        = 8'd255;
   localparam logic [RLEN_W-1:0] READ_LEN_RESET = 8'd100;

   localparam logic [0:0] REG_SEQ_KIND = 1'b0;
   localparam logic [0:0] REG_READ_LEN = 1'b1;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INDEX,
      OP_MARK,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [KEY_W-1:0]     key;
      logic [PW_ADDR_W-1:0] word_addr;
   } op_type;

   typedef struct packed {
      logic              seq_kind;
      logic [RLEN_W-1:0] len_limit;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic             valid;
      logic [NUM_W-1:0] num;
   } entry_type;

   typedef enum logic [1:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_LOOK,
      BS_SETBIT
   } back_state_type;

endpackage

`default_nettype wire

// ----- rtl/kpb_front.sv -----
`default_nettype none

module kpb_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [kpb_pkg::ACT_W-1:0]    req_action,
   input  wire logic [kpb_pkg::CHAR_W-1:0]   req_base_char,
   input  wire logic                         req_last_base,
   input  wire logic [kpb_pkg::PW_ADDR_W-1:0] req_word_address,
   input  wire kpb_pkg::cfg_type             cfg,
   output kpb_pkg::op_type                   op
);

   logic [kpb_pkg::KEY_W-1:0] window_ff, window_in;
   logic [kpb_pkg::RUN_W-1:0] run_ff, run_in;
   logic                      failed_ff, failed_in;
   logic [kpb_pkg::POS_W-1:0] pos_ff, pos_in;

   logic       code_ok;
   logic [1:0] code;
   logic       is_mark;
   logic       take;

   always_comb begin
      code_ok = 1'b1;
      code    = kpb_pkg::CODE_A;
      case (req_base_char)
         kpb_pkg::CHAR_A: code = kpb_pkg::CODE_A;
         kpb_pkg::CHAR_C: code = kpb_pkg::CODE_C;
         kpb_pkg::CHAR_G: code = kpb_pkg::CODE_G;
         kpb_pkg::CHAR_T: code = kpb_pkg::CODE_T;
         default:         code_ok = 1'b0;
      endcase
   end

   always_comb begin
      window_in    = window_ff;
      run_in       = run_ff;
      failed_in    = failed_ff;
      pos_in       = pos_ff;
      op.kind      = kpb_pkg::OP_NONE;
      op.key       = window_ff;
      op.word_addr = req_word_address;
      is_mark      = (req_action == kpb_pkg::ACT_MARK);
      take         = !(cfg.seq_kind && (pos_ff >= cfg.len_limit)) &&
                     !(cfg.seq_kind && is_mark && failed_ff);

      case (req_action) inside
         kpb_pkg::ACT_INDEX, kpb_pkg::ACT_MARK: begin
            if (take) begin
               if (!code_ok) begin
                  run_in = '0;
                  if (cfg.seq_kind && is_mark) begin
                     failed_in = 1'b1;
                  end
               end else begin
                  window_in = {window_ff[kpb_pkg::KEY_W-3:0], code};
                  if (run_ff < kpb_pkg::RUN_W'(kpb_pkg::KMER_LEN)) begin
                     run_in = run_ff + 1'b1;
                  end
                  if (run_in == kpb_pkg::RUN_W'(kpb_pkg::KMER_LEN)) begin
                     op.kind = is_mark ? kpb_pkg::OP_MARK : kpb_pkg::OP_INDEX;
                     op.key  = window_in;
                  end
               end
            end
            if (pos_ff != kpb_pkg::POS_MAX) begin
               pos_in = pos_ff + 1'b1;
            end
            if (req_last_base) begin
               window_in = '0;
               run_in    = '0;
               failed_in = 1'b0;
               pos_in    = '0;
            end
         end
         kpb_pkg::ACT_READ: begin
            op.kind = kpb_pkg::OP_READ;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         run_ff    <= '0;
         failed_ff <= 1'b0;
         pos_ff    <= '0;
      end else if (accept) begin
         window_ff <= window_in;
         run_ff    <= run_in;
         failed_ff <= failed_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kpb_queue.sv -----
`default_nettype none

module kpb_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire kpb_pkg::op_type    push_op,
   input  wire logic               pop,
   output kpb_pkg::op_type         head,
   output kpb_pkg::queue_status_type status
);

   kpb_pkg::op_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in    = wr_ptr_ff ^ push;
      rd_ptr_in    = rd_ptr_ff ^ pop;
      count_in     = count_ff + {1'b0, push} - {1'b0, pop};
      head         = slot_ff[rd_ptr_ff];
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kpb_back.sv -----
`default_nettype none

module kpb_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire kpb_pkg::op_type               head,
   output logic                               pop,
   output logic                               clearing,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic                               rsp_new_entry,
   output logic [kpb_pkg::NUM_W-1:0]          rsp_kmer_index,
   output logic [kpb_pkg::WORD_W-1:0]         rsp_word_data,
   output logic [kpb_pkg::COUNT_W-1:0]        rsp_distinct_total
);

   kpb_pkg::entry_type          tbl_mem [kpb_pkg::TBL_DEPTH];
   logic [kpb_pkg::WORD_W-1:0]  pw_mem  [kpb_pkg::PW_DEPTH];

   kpb_pkg::back_state_type     state_ff, state_in;
   kpb_pkg::op_type             op_ff, op_in;
   logic [kpb_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [kpb_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [kpb_pkg::CLR_W-1:0]   clr_ff, clr_in;

   logic [kpb_pkg::KEY_W-1:0]     tbl_raddr, tbl_waddr;
   logic                          tbl_we;
   kpb_pkg::entry_type            tbl_wdata, tbl_rd_ff;
   logic [kpb_pkg::PW_ADDR_W-1:0] pw_raddr, pw_waddr;
   logic                          pw_we;
   logic [kpb_pkg::WORD_W-1:0]    pw_wdata, pw_rd_ff;

   logic                          emit, emit_hit, emit_new;
   logic [kpb_pkg::NUM_W-1:0]     emit_idx;
   logic [kpb_pkg::WORD_W-1:0]    emit_word;

   logic                          rsp_valid_ff, rsp_hit_ff, rsp_new_ff;
   logic [kpb_pkg::NUM_W-1:0]     rsp_idx_ff;
   logic [kpb_pkg::WORD_W-1:0]    rsp_word_ff;
   logic [kpb_pkg::COUNT_W-1:0]   rsp_total_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kpb_pkg::BS_CLEAR: begin
            if (&clr_ff) begin
               state_in = kpb_pkg::BS_IDLE;
            end
         end
         kpb_pkg::BS_IDLE: begin
            if (!q_empty) begin
               state_in = kpb_pkg::BS_LOOK;
            end
         end
         kpb_pkg::BS_LOOK: begin
            if (op_ff.kind == kpb_pkg::OP_MARK && tbl_rd_ff.valid) begin
               state_in = kpb_pkg::BS_SETBIT;
            end else begin
               state_in = kpb_pkg::BS_IDLE;
            end
         end
         kpb_pkg::BS_SETBIT: state_in = kpb_pkg::BS_IDLE;
         default:            state_in = kpb_pkg::BS_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in     = op_ff;
      num_in    = num_ff;
      count_in  = count_ff;
      clr_in    = clr_ff;
      pop       = 1'b0;
      clearing  = 1'b0;
      tbl_raddr = head.key;
      tbl_we    = 1'b0;
      tbl_waddr = op_ff.key;
      tbl_wdata = '{valid: 1'b1, num: count_ff[kpb_pkg::NUM_W-1:0]};
      pw_raddr  = head.word_addr;
      pw_we     = 1'b0;
      pw_waddr  = op_ff.word_addr;
      pw_wdata  = '0;
      emit      = 1'b0;
      emit_hit  = 1'b0;
      emit_new  = 1'b0;
      emit_idx  = '0;
      emit_word = '0;

      unique case (state_ff)
         kpb_pkg::BS_CLEAR: begin
            clearing  = 1'b1;
            clr_in    = clr_ff + 1'b1;
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff[kpb_pkg::KEY_W-1:0];
            tbl_wdata = '0;
            pw_we     = 1'b1;
            pw_waddr  = clr_ff[kpb_pkg::PW_ADDR_W-1:0];
         end
         kpb_pkg::BS_IDLE: begin
            if (!q_empty) begin
               pop   = 1'b1;
               op_in = head;
            end
         end
         kpb_pkg::BS_LOOK: begin
            // presence word of the matched number, used by the bit set
            pw_raddr = tbl_rd_ff.num[kpb_pkg::NUM_W-1:kpb_pkg::BIT_W];
            case (op_ff.kind)
               kpb_pkg::OP_READ: begin
                  emit      = 1'b1;
                  emit_word = pw_rd_ff;
                  pw_we     = 1'b1;
               end
               kpb_pkg::OP_INDEX: begin
                  emit = 1'b1;
                  if (tbl_rd_ff.valid) begin
                     emit_hit = 1'b1;
                     emit_idx = tbl_rd_ff.num;
                  end else if (!count_ff[kpb_pkg::COUNT_W-1]) begin
                     tbl_we   = 1'b1;
                     emit_hit = 1'b1;
                     emit_new = 1'b1;
                     emit_idx = count_ff[kpb_pkg::NUM_W-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end
               kpb_pkg::OP_MARK: begin
                  num_in = tbl_rd_ff.num;
                  emit   = !tbl_rd_ff.valid;
               end
               default: begin
                  emit = 1'b1;
               end
            endcase
         end
         kpb_pkg::BS_SETBIT: begin
            emit     = 1'b1;
            emit_hit = 1'b1;
            emit_idx = num_ff;
            pw_we    = 1'b1;
            pw_waddr = num_ff[kpb_pkg::NUM_W-1:kpb_pkg::BIT_W];
            pw_wdata = pw_rd_ff |
                       (kpb_pkg::WORD_W'(1) << num_ff[kpb_pkg::BIT_W-1:0]);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tbl_rd_ff <= tbl_mem[tbl_raddr];
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      pw_rd_ff <= pw_mem[pw_raddr];
      if (pw_we) begin
         pw_mem[pw_waddr] <= pw_wdata;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      num_ff <= num_in;
      if (emit) begin
         rsp_hit_ff   <= emit_hit;
         rsp_new_ff   <= emit_new;
         rsp_idx_ff   <= emit_idx;
         rsp_word_ff  <= emit_word;
         rsp_total_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpb_pkg::BS_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= emit;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_new_entry      = rsp_new_ff;
   assign rsp_kmer_index     = rsp_idx_ff;
   assign rsp_word_data      = rsp_word_ff;
   assign rsp_distinct_total = rsp_total_ff;

endmodule

`default_nettype wire

// ----- rtl/kmer_presence_bitvector.sv -----
`default_nettype none

// k-mer presence bitvector.
// Items enter on start/busy: an item is taken at a clock edge with start high
// and busy low. req_action selects an index-pass base, a mark-pass base or a
// read-and-clear of one 64-bit presence word (req_word_address).
// Every item gives exactly one result, shown for one cycle with rsp_valid high.
// The front tracks the rolling window and run state at accept time and hands
// table work to the back through a two-entry queue; busy rises when the queue
// is full.
// The result strobe is registered after the back end pops the item and reads
// the k-mer table; a mark-pass hit needs a second memory access for its
// presence word. The back end works on one item at a time, through its idle
// and lookup states plus a bit-set state for a mark-pass hit, while the queue
// keeps taking new items. After reset the back end sweeps both memories,
// holding busy high; configuration writes over the APB port are taken meanwhile.
// The receiver cannot stall: results are never held off.

module kmer_presence_bitvector (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [kpb_pkg::ACT_W-1:0]       req_action,
   input  wire logic [kpb_pkg::CHAR_W-1:0]      req_base_char,
   input  wire logic                            req_last_base,
   input  wire logic [kpb_pkg::PW_ADDR_W-1:0]   req_word_address,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic                                 rsp_new_entry,
   output logic [kpb_pkg::NUM_W-1:0]            rsp_kmer_index,
   output logic [kpb_pkg::WORD_W-1:0]           rsp_word_data,
   output logic [kpb_pkg::COUNT_W-1:0]          rsp_distinct_total,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [kpb_pkg::PADDR_W-1:0]     paddr,
   input  wire logic [kpb_pkg::CSR_W-1:0]       pwdata,
   output logic [kpb_pkg::CSR_W-1:0]            prdata,
   output logic                                 pready
);

   logic                        seq_kind_ff;
   logic [kpb_pkg::RLEN_W-1:0]  len_limit_ff;
   kpb_pkg::cfg_type            cfg;
   logic                        csr_write;
   logic                        accept;
   logic                        pop;
   logic                        clearing;
   kpb_pkg::op_type             front_op, head;
   kpb_pkg::queue_status_type   q_status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign cfg       = '{seq_kind: seq_kind_ff, len_limit: len_limit_ff};
   assign busy      = q_status.full || clearing;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_kind_ff  <= 1'b0;
         len_limit_ff <= kpb_pkg::READ_LEN_RESET;
      end else if (csr_write) begin
         unique case (paddr[2:2])
            kpb_pkg::REG_SEQ_KIND: seq_kind_ff <= pwdata[0];
            kpb_pkg::REG_READ_LEN: len_limit_ff <= pwdata[kpb_pkg::RLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2:2])
         kpb_pkg::REG_SEQ_KIND: prdata = kpb_pkg::CSR_W'(seq_kind_ff);
         kpb_pkg::REG_READ_LEN: prdata = kpb_pkg::CSR_W'(len_limit_ff);
         default:               prdata = '0;
      endcase
   end

   kpb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_action       (req_action),
      .req_base_char    (req_base_char),
      .req_last_base    (req_last_base),
      .req_word_address (req_word_address),
      .cfg              (cfg),
      .op               (front_op)
   );

   kpb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .push_op (front_op),
      .pop     (pop),
      .head    (head),
      .status  (q_status)
   );

   kpb_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_status.empty),
      .head               (head),
      .pop                (pop),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_new_entry      (rsp_new_entry),
      .rsp_kmer_index     (rsp_kmer_index),
      .rsp_word_data      (rsp_word_data),
      .rsp_distinct_total (rsp_distinct_total)
   );

endmodule

`default_nettype wire
